/* design/assert_macros.svh */
// Assertion macros shared by the lookup engine RTL.
// Every assertion samples on the rising edge of clk and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every sampled edge.
`define IPV6LPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define IPV6LPM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* design/ipv6lpm_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6lpm_pkg
// Types, sizes and codes of the IPv6 multibit-trie longest-prefix-match engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6lpm_pkg;

    localparam int unsigned WIDE_NODES   = 2;
    localparam int unsigned NARROW_NODES = 1024;
    localparam int unsigned WIDE_LEVELS  = 1;
    localparam int unsigned HOP_BITS     = 32;

    localparam int unsigned WIDE_STRIDE   = 16;
    localparam int unsigned NARROW_STRIDE = 8;
    localparam int unsigned WIDE_SLOTS    = 1 << WIDE_STRIDE;
    localparam int unsigned NARROW_SLOTS  = 1 << NARROW_STRIDE;
    localparam int unsigned WIDE_DEPTH    = WIDE_NODES * WIDE_SLOTS;
    localparam int unsigned NARROW_DEPTH  = NARROW_NODES * NARROW_SLOTS;
    localparam int unsigned WA_W          = $clog2(WIDE_DEPTH);
    localparam int unsigned NA_W          = $clog2(NARROW_DEPTH);
    localparam int unsigned ADDR_BYTES    = 16;
    localparam int unsigned CHILD_W       = 10;

    // Request codes.
    localparam logic [1:0] REQ_LOOKUP       = 2'd0;
    localparam logic [1:0] REQ_WIDE_WRITE   = 2'd1;
    localparam logic [1:0] REQ_NARROW_WRITE = 2'd2;
    localparam logic [1:0] REQ_RESERVED     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOOKUP_ENABLE = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_VALID = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_HOP   = 2'd2;
    localparam logic [1:0] CFG_ROOT_NODE     = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [17:0] entry_address;
        logic        entry_valid;
        logic        entry_wide_child;
        logic [9:0]  entry_child;
        logic [31:0] entry_hop;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] route_hop;
    } rsp_t;

    typedef struct packed {
        logic        lookup_enable;
        logic        default_valid;
        logic [31:0] default_hop;
        logic        root_node;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic                wide_child;
        logic [CHILD_W-1:0]  child;
        logic [HOP_BITS-1:0] hop;
    } entry_t;

    typedef struct packed {
        logic            wide_en;
        logic [WA_W-1:0] wide_addr;
        logic            narrow_en;
        logic [NA_W-1:0] narrow_addr;
    } rd_req_t;

    typedef enum logic [2:0] {
        LK_IDLE,
        LK_ISSUE,
        LK_WIDE,
        LK_NARROW,
        LK_DONE
    } lk_state_t;

    // Byte i of the 128-bit address, byte 0 in the top bits.
    function automatic logic [7:0] addr_byte(input logic [127:0] a, input logic [4:0] i);
        logic [6:0] sh;
        sh = {~i[3:0], 3'b000};
        return 8'(a >> sh);
    endfunction

endpackage

`default_nettype wire

/* design/ipv6_wide_stride_lpm_lookup_top.sv */
// ----------------------------------------------------------------------------
// ipv6_wide_stride_lpm_lookup_top
// IPv6 longest-prefix-match engine over a multibit trie held in two RAMs.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   req      in         req_valid / req_ready  lookup or store-entry write
//   rsp      out        rsp_valid / rsp_ready  found flag and next hop
//   cfg      in         cfg_valid / cfg_ready  register index and data
//
// A store write gives no result.
// A lookup reads the trie level by level and then registers its result;
// each level is one read of the wide or narrow RAM.
// With lookups disabled the walker skips the reads and goes to its final state.
// Requests are taken only while the walker is idle; a full result register
// holds the walker in its final state until the word is taken.
// The RAMs are not cleared after reset; configuration registers reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ipv6_wide_stride_lpm_lookup_top
    import ipv6lpm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t            cfg_reg, cfg_next;
    logic            walk_idle;
    logic            req_fire;
    logic [31:0]     entry_addr32;
    logic            wide_we;
    logic            narrow_we;
    entry_t          wr_entry;
    rd_req_t         rd;
    entry_t          wide_rdata;
    entry_t          narrow_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOOKUP_ENABLE: cfg_next.lookup_enable = cfg_data[0];
                CFG_DEFAULT_VALID: cfg_next.default_valid = cfg_data[0];
                CFG_DEFAULT_HOP:   cfg_next.default_hop   = cfg_data;
                CFG_ROOT_NODE:     cfg_next.root_node     = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign req_ready    = walk_idle;
    assign req_fire     = req_valid && req_ready;
    assign entry_addr32 = 32'(req.entry_address);

    // Writes beyond the end of their store are dropped.
    assign wide_we   = req_fire && (req.req_type == REQ_WIDE_WRITE)
                       && (entry_addr32 < WIDE_DEPTH);
    assign narrow_we = req_fire && (req.req_type == REQ_NARROW_WRITE)
                       && (entry_addr32 < NARROW_DEPTH);

    always_comb
    begin
        wr_entry.valid      = req.entry_valid;
        wr_entry.wide_child = req.entry_wide_child;
        wr_entry.child      = req.entry_child;
        wr_entry.hop        = req.entry_hop[HOP_BITS-1:0];
    end

    ipv6lpm_ram #(
        .DEPTH (WIDE_DEPTH),
        .WIDTH ($bits(entry_t))
    ) u_wide_ram (
        .clk   (clk),
        .we    (wide_we),
        .waddr (entry_addr32[WA_W-1:0]),
        .wdata (wr_entry),
        .re    (rd.wide_en),
        .raddr (rd.wide_addr),
        .rdata (wide_rdata)
    );

    ipv6lpm_ram #(
        .DEPTH (NARROW_DEPTH),
        .WIDTH ($bits(entry_t))
    ) u_narrow_ram (
        .clk   (clk),
        .we    (narrow_we),
        .waddr (entry_addr32[NA_W-1:0]),
        .wdata (wr_entry),
        .re    (rd.narrow_en),
        .raddr (rd.narrow_addr),
        .rdata (narrow_rdata)
    );

    ipv6lpm_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (req_fire && (req.req_type == REQ_LOOKUP)),
        .start_addr   ({req.addr_high, req.addr_low}),
        .idle         (walk_idle),
        .rd           (rd),
        .wide_rdata   (wide_rdata),
        .narrow_rdata (narrow_rdata),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp)
    );

    `IPV6LPM_ASSERT(a_write_idle, (wide_we || narrow_we) |-> walk_idle, "store write during a walk")
    `IPV6LPM_ASSERT(a_one_write, !(wide_we && narrow_we), "both stores written at once")
    `IPV6LPM_ASSERT_NEXT(a_reserved_quiet, req_fire && (req.req_type == REQ_RESERVED), walk_idle, "reserved request started work")

endmodule

`default_nettype wire

/* design/ipv6lpm_ram.sv */
// ----------------------------------------------------------------------------
// ipv6lpm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6lpm_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/ipv6lpm_walk.sv */
// ----------------------------------------------------------------------------
// ipv6lpm_walk
// Trie walker: one store read per level, best-match tracking, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ipv6lpm_walk
    import ipv6lpm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         start,
    input  wire logic [127:0] start_addr,
    output logic              idle,
    output rd_req_t           rd,
    input  wire entry_t       wide_rdata,
    input  wire entry_t       narrow_rdata,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output rsp_t              rsp
);

    lk_state_t           state_reg, state_next;
    logic [127:0]        addr_reg, addr_next;
    logic [CHILD_W-1:0]  node_reg, node_next;
    logic                wide_reg, wide_next;
    logic [1:0]          levels_reg, levels_next;
    logic [4:0]          byte_reg, byte_next;
    logic                found_reg, found_next;
    logic [HOP_BITS-1:0] best_reg, best_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic [CHILD_W-1:0]  cand_node;
    logic                cand_wide;
    logic [1:0]          cand_levels;
    logic [4:0]          cand_byte;
    logic                cand_found;
    logic [HOP_BITS-1:0] cand_best;
    logic                step;
    logic                stop;
    logic [15:0]         widx;
    logic [7:0]          nidx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LK_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        node_reg   <= node_next;
        wide_reg   <= wide_next;
        levels_reg <= levels_next;
        byte_reg   <= byte_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        node_next      = node_reg;
        wide_next      = wide_reg;
        levels_next    = levels_reg;
        byte_next      = byte_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        rd             = '0;
        cand_node      = node_reg;
        cand_wide      = wide_reg;
        cand_levels    = levels_reg;
        cand_byte      = byte_reg;
        cand_found     = found_reg;
        cand_best      = best_reg;
        step           = 1'b0;
        stop           = 1'b0;
        widx           = '0;
        nidx           = '0;

        unique case (state_reg)
            LK_IDLE:
            begin
                if (start)
                begin
                    addr_next   = start_addr;
                    node_next   = CHILD_W'(cfg.root_node);
                    wide_next   = 1'b1;
                    levels_next = '0;
                    byte_next   = '0;
                    found_next  = cfg.lookup_enable && cfg.default_valid;
                    best_next   = (cfg.lookup_enable && cfg.default_valid)
                                  ? cfg.default_hop[HOP_BITS-1:0] : '0;
                    state_next  = cfg.lookup_enable ? LK_ISSUE : LK_DONE;
                end
            end
            LK_ISSUE:
            begin
                step = 1'b1;
            end
            LK_WIDE:
            begin
                if (wide_rdata.valid)
                begin
                    cand_found = 1'b1;
                    cand_best  = wide_rdata.hop;
                end
                cand_levels = levels_reg + 2'd1;
                cand_byte   = 5'({cand_levels, 1'b0});
                // A wide entry has a child when either the index or the wide flag is set.
                if (wide_rdata.child == '0 && !wide_rdata.wide_child)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    cand_node = wide_rdata.child;
                    cand_wide = wide_rdata.wide_child;
                    step      = 1'b1;
                end
            end
            LK_NARROW:
            begin
                if (narrow_rdata.valid)
                begin
                    cand_found = 1'b1;
                    cand_best  = narrow_rdata.hop;
                end
                cand_byte = byte_reg + 5'd1;
                if (narrow_rdata.child == '0)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    cand_node = narrow_rdata.child;
                    cand_wide = 1'b0;
                    step      = 1'b1;
                end
            end
            LK_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.found     = found_reg;
                    rsp_next.route_hop = found_reg ? 32'(best_reg) : '0;
                    state_next         = LK_IDLE;
                end
            end
            default:
            begin
                state_next = LK_IDLE;
            end
        endcase

        // Pick the next read from the node just reached; wide levels come first.
        if (step)
        begin
            if (cand_wide && 32'(cand_levels) < WIDE_LEVELS)
            begin
                if (32'(cand_node) >= WIDE_NODES)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    widx = {addr_byte(addr_reg, 5'({cand_levels, 1'b0})),
                            addr_byte(addr_reg, 5'({cand_levels, 1'b1}))};
                    rd.wide_en   = 1'b1;
                    rd.wide_addr = WA_W'((32'(cand_node) << WIDE_STRIDE) | 32'(widx));
                    state_next   = LK_WIDE;
                end
            end
            else if (32'(cand_byte) >= ADDR_BYTES || cand_node == '0
                     || 32'(cand_node) >= NARROW_NODES)
            begin
                stop = 1'b1;
            end
            else
            begin
                nidx           = addr_byte(addr_reg, cand_byte);
                rd.narrow_en   = 1'b1;
                rd.narrow_addr = NA_W'((32'(cand_node) << NARROW_STRIDE) | 32'(nidx));
                state_next     = LK_NARROW;
            end
        end

        if (stop)
        begin
            state_next = LK_DONE;
        end

        if (state_reg != LK_IDLE)
        begin
            node_next   = cand_node;
            wide_next   = cand_wide;
            levels_next = cand_levels;
            byte_next   = cand_byte;
            found_next  = cand_found;
            best_next   = cand_best;
        end
    end

    assign idle      = (state_reg == LK_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `IPV6LPM_ASSERT(a_one_store_read, !(rd.wide_en && rd.narrow_en), "both stores read at once")
    `IPV6LPM_ASSERT(a_no_read_idle, (state_reg == LK_IDLE) |-> !(rd.wide_en || rd.narrow_en), "read while idle")
    `IPV6LPM_ASSERT(a_start_idle, start |-> (state_reg == LK_IDLE), "lookup started while busy")
    `IPV6LPM_ASSERT(a_miss_zero, (rsp_valid_reg && !rsp_reg.found) |-> (rsp_reg.route_hop == '0), "miss with nonzero hop")
    `IPV6LPM_ASSERT_NEXT(a_read_then_check, rd.wide_en, (state_reg == LK_WIDE), "wide read not checked")

endmodule

`default_nettype wire
